// ----- hdl/memory_bus_with_screen_mirror_defines.svh -----
// ----------------------------------------------------------------------------
// Memory bus with screen mirror: assertion macros
// Shared concurrent check forms for the bus block, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MEMORY_BUS_WITH_SCREEN_MIRROR_DEFINES_SVH
`define MEMORY_BUS_WITH_SCREEN_MIRROR_DEFINES_SVH

// Same-cycle implication.
`define MBSM_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MBSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mbsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Memory bus with screen mirror: shared package
// Bus access codes, decode addresses, screen info word and code conversion.
// ----------------------------------------------------------------------------
package mbsm_pkg;

    // Access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Fixed decode addresses
    localparam logic [15:0] ADDR_RASTER  = 16'hD012;
    localparam logic [15:0] ADDR_KEYPORT = 16'hDC01;
    localparam logic [15:0] WIN_FIRST    = 16'h0400;
    localparam logic [15:0] WIN_LAST     = 16'h07E7;

    localparam logic [7:0] KEYPORT_DATA = 8'hFF;

    // ASCII codes used by the screen code conversion
    localparam logic [6:0] CH_AT     = 7'h40;
    localparam logic [6:0] CH_BLANK  = 7'h20;
    localparam logic [6:0] CH_LBRACK = 7'h5B;
    localparam logic [6:0] CH_RBRACK = 7'h5D;
    localparam logic [6:0] CH_CARET  = 7'h5E;
    localparam logic [6:0] CH_LESS   = 7'h3C;

    // Source of the read byte
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_RAM,
        SRC_RASTER,
        SRC_KEYPORT
    } rd_src_t;

    // Screen report for one write
    typedef struct packed {
        logic       valid;
        logic [4:0] row;
        logic [5:0] col;
        logic [6:0] ch;
        logic [5:0] cursor;
    } screen_info_t;

    // Screen code to ASCII; only the low 7 bits of the code count.
    function automatic logic [6:0] to_ascii(input logic [7:0] code);
        logic [6:0] m;
        logic [6:0] res;
        m = code[6:0];
        case (m) inside
            7'd0:            res = CH_AT;
            [7'd1:7'd26]:    res = CH_AT + m;
            7'd27:           res = CH_LBRACK;
            7'd28:           res = CH_BLANK;
            7'd29:           res = CH_RBRACK;
            7'd30:           res = CH_CARET;
            7'd31:           res = CH_LESS;
            [7'd32:7'd63]:   res = m;
            default:         res = CH_BLANK;
        endcase
        return res;
    endfunction

endpackage

// ----- hdl/mbsm_screen_map.sv -----
// ----------------------------------------------------------------------------
// Memory bus with screen mirror: screen window mapper
// Two-stage row/column split of a screen write by a constant column count.
// ----------------------------------------------------------------------------
module mbsm_screen_map
    import mbsm_pkg::*;
#(
    parameter int SCREEN_COLS = 40
)
(
    input  logic         clk,
    input  logic         accept,
    input  logic         opcode,
    input  logic [15:0]  address,
    input  logic [7:0]   write_data,
    output screen_info_t info
);

    // Reciprocal of the column count, scaled by 2^16; quotient estimate is
    // low by at most one.
    localparam logic [16:0] RECIP = 17'(65536 / SCREEN_COLS);
    localparam logic [7:0]  COLS  = 8'(SCREEN_COLS);

    logic        in_win;
    logic [9:0]  offset;
    logic [26:0] prod;

    logic        in_win_reg;
    logic [9:0]  offset_reg;
    logic [9:0]  quot_est_reg;
    logic [6:0]  ch_reg;

    logic [17:0] back_prod;
    logic [17:0] rem_wide;
    logic [8:0]  rem;
    logic        fix;
    logic [7:0]  col_full;
    logic [9:0]  row_full;

    assign in_win = (opcode == OP_WRITE) && (address >= WIN_FIRST) && (address <= WIN_LAST);
    assign offset = 10'(address - WIN_FIRST);
    assign prod   = 27'(offset) * 27'(RECIP);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_win_reg   <= in_win;
            offset_reg   <= offset;
            quot_est_reg <= prod[25:16];
            ch_reg       <= to_ascii(write_data);
        end
    end

    // Correct the estimate: one compare and subtract.
    assign back_prod = 18'(quot_est_reg) * 18'(COLS);
    assign rem_wide  = 18'(offset_reg) - back_prod;
    assign rem       = rem_wide[8:0];
    assign fix       = (rem >= 9'(COLS));
    assign col_full  = fix ? 8'(rem - 9'(COLS)) : rem[7:0];
    assign row_full  = quot_est_reg + 10'(fix);

    always_comb
    begin
        info = '0;
        if (in_win_reg)
        begin
            info.valid  = 1'b1;
            info.row    = row_full[4:0];
            info.col    = col_full[5:0];
            info.ch     = ch_reg;
            info.cursor = 6'(col_full + 8'd1);
        end
    end

endmodule

// ----- hdl/memory_bus_with_screen_mirror.sv -----
// ----------------------------------------------------------------------------
// Memory bus with screen mirror
// Byte RAM with a raster line register, a fixed key port and screen reports.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive opcode, address and write_data with start high; the
//   word is taken at a rising edge where start is high and busy is low. busy
//   stays low, so a new access can be issued every cycle.
//   Result channel: done is high for exactly one cycle with read_data and the
//   screen fields; the receiver cannot hold results off and must take them.
//   A word passes the RAM read register, then the result register, before done
//   rises with its result. Throughput: one word per cycle, set by the single
//   RAM port that serves one read or one write per access.
//   Reading the raster address bumps the line counter and returns its new low
//   byte; reading the key port returns all ones; a write in the screen window
//   also reports row, column, ASCII char and cursor column.
//   Reset: clears the line counter and the result pipeline; RAM holds no reset
//   value and must be written before it is read.
// ----------------------------------------------------------------------------
`include "memory_bus_with_screen_mirror_defines.svh"

module memory_bus_with_screen_mirror
    import mbsm_pkg::*;
#(
    parameter int MEM_DEPTH    = 65536,
    parameter int RASTER_LINES = 312,
    parameter int SCREEN_COLS  = 40
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        done,
    output logic [7:0]  read_data,
    output logic        screen_valid,
    output logic [4:0]  screen_row,
    output logic [5:0]  screen_col,
    output logic [6:0]  screen_char,
    output logic [5:0]  cursor_col
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic accept;

    // Line counter
    logic [8:0] raster_reg;
    logic [8:0] raster_next;
    logic [8:0] raster_plus;
    logic       raster_hit;

    // RAM
    logic [7:0]    mem [0:MEM_DEPTH-1];
    logic [20:0]   idx_rem;
    logic [AW-1:0] mem_idx;
    logic [7:0]    mem_rdata_reg;

    // Stage one
    logic    s1_valid_reg;
    rd_src_t s1_src_reg;
    rd_src_t src_next;
    logic [7:0] s1_raster_reg;

    screen_info_t scr_info;

    // Result register
    logic         done_reg;
    logic [7:0]   read_data_reg;
    logic [7:0]   read_data_next;
    screen_info_t scr_reg;

    // Never stall: busy is tied low and every access is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---- line counter: advance on a read of the raster address ----
    assign raster_hit  = accept && (opcode == OP_READ) && (address == ADDR_RASTER);
    assign raster_plus = raster_reg + 9'd1;
    assign raster_next = (raster_plus == 9'(RASTER_LINES)) ? 9'd0 : raster_plus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raster_reg <= '0;
        end
        else if (raster_hit)
        begin
            raster_reg <= raster_next;
        end
    end

    // ---- RAM index: address reduced by the depth, five conditional subtracts ----
    always_comb
    begin
        idx_rem = 21'(address);
        for (int k = 4; k >= 0; k--)
        begin
            if (idx_rem >= (21'(MEM_DEPTH) << k))
            begin
                idx_rem = idx_rem - (21'(MEM_DEPTH) << k);
            end
        end
    end

    assign mem_idx = idx_rem[AW-1:0];

    // Single port: write on a write access, registered read otherwise.
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == OP_WRITE))
        begin
            mem[mem_idx] <= write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (opcode == OP_READ))
        begin
            mem_rdata_reg <= mem[mem_idx];
        end
    end

    // ---- decode the read source at accept ----
    always_comb
    begin
        if (opcode == OP_WRITE)
            src_next = SRC_NONE;
        else if (address == ADDR_RASTER)
            src_next = SRC_RASTER;
        else if (address == ADDR_KEYPORT)
            src_next = SRC_KEYPORT;
        else
            src_next = SRC_RAM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // Hold the source and the new line value alongside the RAM read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_reg    <= src_next;
            s1_raster_reg <= raster_next[7:0];
        end
    end

    mbsm_screen_map #(
        .SCREEN_COLS (SCREEN_COLS)
    ) u_screen_map (
        .clk        (clk),
        .accept     (accept),
        .opcode     (opcode),
        .address    (address),
        .write_data (write_data),
        .info       (scr_info)
    );

    // ---- select the read byte and load the result register ----
    always_comb
    begin
        unique case (s1_src_reg)
            SRC_NONE:    read_data_next = 8'h00;
            SRC_RAM:     read_data_next = mem_rdata_reg;
            SRC_RASTER:  read_data_next = s1_raster_reg;
            SRC_KEYPORT: read_data_next = KEYPORT_DATA;
            default:     read_data_next = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            read_data_reg <= read_data_next;
            scr_reg       <= scr_info;
        end
    end

    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign screen_valid = scr_reg.valid;
    assign screen_row   = scr_reg.row;
    assign screen_col   = scr_reg.col;
    assign screen_char  = scr_reg.ch;
    assign cursor_col   = scr_reg.cursor;

    // ---- checks ----
    `MBSM_ASSERT_NEXT(a_result_follows, accept, ##1 done, "accepted word gave no result")
    `MBSM_ASSERT(a_raster_range, 1'b1, raster_reg < 9'(RASTER_LINES), "line counter out of range")
    `MBSM_ASSERT_NEXT(a_raster_hold, !raster_hit, $stable(raster_reg), "line counter moved without a raster read")
    `MBSM_ASSERT(a_screen_write_zero, done && screen_valid, read_data == 8'h00, "screen write returned read data")

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Memory bus with screen mirror: self-checking testbench
// Issues read and write words to the bus block, predicts the RAM image, the
// raster line counter and the screen reports, and checks every result word.
// ----------------------------------------------------------------------------
module testbench
    import mbsm_pkg::*;
();

    localparam int RASTER_LINES = 312;
    localparam int SCREEN_COLS  = 40;
    localparam int RANDOM_WORDS = 650;
    localparam int RASTER_RUN   = 320;      // long enough to wrap the line counter
    localparam int CYCLE_LIMIT  = 200000;

    // One bus access as the sender issues it.
    typedef struct {
        logic        opcode;
        logic [15:0] address;
        logic [7:0]  data;
        bit          drain;     // hold off until every result word is back
    } bus_word_t;

    // One result word as the block reports it.
    typedef struct packed {
        logic [7:0] read_data;
        logic       screen_valid;
        logic [4:0] screen_row;
        logic [5:0] screen_col;
        logic [6:0] screen_char;
        logic [5:0] cursor_col;
    } bus_result_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic        opcode     = OP_READ;
    logic [15:0] address    = '0;
    logic [7:0]  write_data = '0;
    logic        busy;
    logic        done;
    logic [7:0]  read_data;
    logic        screen_valid;
    logic [4:0]  screen_row;
    logic [5:0]  screen_col;
    logic [6:0]  screen_char;
    logic [5:0]  cursor_col;

    bus_word_t   pending_words[$];
    bus_result_t expected_results[$];

    // Predictor state: RAM image and raster line counter.
    logic [7:0]  ram_image [0:65535];
    logic [8:0]  raster_line;

    int fail_count  = 0;
    int cycle_count = 0;
    int burst_left  = 1;
    int gap_left    = 0;

    memory_bus_with_screen_mirror DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .address      (address),
        .write_data   (write_data),
        .done         (done),
        .read_data    (read_data),
        .screen_valid (screen_valid),
        .screen_row   (screen_row),
        .screen_col   (screen_col),
        .screen_char  (screen_char),
        .cursor_col   (cursor_col)
    );

    always #6 clk = ~clk;

    // Map a screen code to the character it shows; only the low 7 bits count.
    function automatic logic [6:0] screen_ascii(input logic [7:0] code);
        logic [6:0] m;
        m = code[6:0];
        if (m > 7'd63)
            return 7'h20;
        if (m == 7'd0)
            return 7'h40;
        if (m <= 7'd26)
            return 7'h40 + m;
        case (m)
            7'd27:   return 7'h5B;
            7'd28:   return 7'h20;
            7'd29:   return 7'h5D;
            7'd30:   return 7'h5E;
            7'd31:   return 7'h3C;
            default: return m;
        endcase
    endfunction

    // Advance the predictor by one accepted word and queue the result it must give.
    function void predict_access(input logic op, input logic [15:0] addr,
                                 input logic [7:0] data);
        bus_result_t res;
        int          offset;
        res = '0;
        if (op == OP_READ)
        begin
            if (addr == ADDR_RASTER)
            begin
                // Bump first, then report the new low byte.
                raster_line    = (raster_line == RASTER_LINES - 1) ? 9'd0 : raster_line + 9'd1;
                res.read_data  = raster_line[7:0];
            end
            else if (addr == ADDR_KEYPORT)
                res.read_data = 8'hFF;
            else
                res.read_data = ram_image[addr];
        end
        else
        begin
            // Every write lands in RAM, even at the decoded addresses.
            ram_image[addr] = data;
            if (addr >= WIN_FIRST && addr <= WIN_LAST)
            begin
                offset           = addr - WIN_FIRST;
                res.screen_valid = 1'b1;
                res.screen_row   = 5'(offset / SCREEN_COLS);
                res.screen_col   = 6'(offset % SCREEN_COLS);
                res.screen_char  = screen_ascii(data);
                res.cursor_col   = 6'(offset % SCREEN_COLS + 1);
            end
        end
        expected_results.push_back(res);
    endfunction

    function void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Driver: predict on the accepting edge, then pick the next word or idle.
    // Bursts of random length alternate with random gaps; a word marked drain
    // waits until the result queue has run dry.
    always @(posedge clk or negedge rst_n)
    begin : drive_bus
        bus_word_t nxt;
        logic      go;
        if (!rst_n)
        begin
            start       <= 1'b0;
            opcode      <= OP_READ;
            address     <= '0;
            write_data  <= '0;
            raster_line =  '0;
            burst_left  =  1;
            gap_left    =  0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_access(opcode, address, write_data);
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            // Hold the word while the block is busy; otherwise choose what comes next.
            if (!(start && busy))
            begin
                go = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain && expected_results.size() != 0))
                begin
                    nxt        = pending_words.pop_front();
                    go         = 1'b1;
                    opcode     <= nxt.opcode;
                    address    <= nxt.address;
                    write_data <= nxt.data;
                end
                start <= go;
            end
        end
    end

    // Monitor: every strobed result word must match the oldest expectation.
    always @(posedge clk)
    begin : watch_results
        bus_result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with no access waiting: read_data %0h", read_data);
                fail_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                check_field("read_data",    exp_res.read_data,    read_data);
                check_field("screen_valid", exp_res.screen_valid, screen_valid);
                check_field("screen_row",   exp_res.screen_row,   screen_row);
                check_field("screen_col",   exp_res.screen_col,   screen_col);
                check_field("screen_char",  exp_res.screen_char,  screen_char);
                check_field("cursor_col",   exp_res.cursor_col,   cursor_col);
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus: directed words, then weighted random traffic.
    initial
    begin : stimulus
        logic [15:0] written_addrs[$];
        logic [15:0] odd_addrs[6];
        logic [15:0] a;
        int          pick;
        int          count;

        odd_addrs = '{ADDR_RASTER, ADDR_KEYPORT, WIN_FIRST - 16'd1, WIN_LAST + 16'd1,
                      16'h0000, 16'hFFFF};

        // Directed: address and data extremes, window edges, each screen code class,
        // writes to the decoded addresses, raster and key port reads.
        pending_words.push_back('{OP_WRITE, 16'h0000, 8'h00, 1'b0});
        pending_words.push_back('{OP_WRITE, 16'hFFFF, 8'hFF, 1'b0});
        pending_words.push_back('{OP_READ,  16'h0000, 8'hFF, 1'b0});
        pending_words.push_back('{OP_READ,  16'hFFFF, 8'h00, 1'b0});
        pending_words.push_back('{OP_WRITE, WIN_FIRST, 8'h00, 1'b0});
        pending_words.push_back('{OP_WRITE, WIN_LAST,  8'h1A, 1'b0});
        pending_words.push_back('{OP_WRITE, WIN_FIRST - 16'd1, 8'h55, 1'b0});
        pending_words.push_back('{OP_WRITE, WIN_LAST + 16'd1,  8'hAA, 1'b0});
        pending_words.push_back('{OP_WRITE, 16'h0427, 8'd27, 1'b0});    // end of row 0
        pending_words.push_back('{OP_WRITE, 16'h0428, 8'd28, 1'b0});    // start of row 1
        pending_words.push_back('{OP_WRITE, 16'h0500, 8'd29, 1'b0});
        pending_words.push_back('{OP_WRITE, 16'h0600, 8'd30, 1'b0});
        pending_words.push_back('{OP_WRITE, 16'h0700, 8'd31, 1'b0});
        pending_words.push_back('{OP_WRITE, 16'h0401, 8'd32, 1'b0});
        pending_words.push_back('{OP_WRITE, 16'h0402, 8'd63, 1'b0});
        pending_words.push_back('{OP_WRITE, 16'h0403, 8'd64, 1'b0});    // first blank code
        pending_words.push_back('{OP_WRITE, 16'h0404, 8'h80, 1'b0});    // masks to zero
        pending_words.push_back('{OP_WRITE, 16'h0405, 8'hFF, 1'b0});
        pending_words.push_back('{OP_READ,  WIN_LAST, 8'h00, 1'b0});
        pending_words.push_back('{OP_READ,  WIN_FIRST - 16'd1, 8'h00, 1'b0});
        pending_words.push_back('{OP_READ,  ADDR_RASTER,  8'h3C, 1'b1});
        pending_words.push_back('{OP_READ,  ADDR_KEYPORT, 8'h00, 1'b0});
        pending_words.push_back('{OP_WRITE, ADDR_RASTER,  8'h77, 1'b0}); // must not bump lines
        pending_words.push_back('{OP_WRITE, ADDR_KEYPORT, 8'h12, 1'b0});
        pending_words.push_back('{OP_READ,  ADDR_RASTER,  8'hC3, 1'b0});
        pending_words.push_back('{OP_READ,  ADDR_KEYPORT, 8'h5A, 1'b0});
        written_addrs = '{16'h0000, 16'hFFFF, WIN_FIRST, WIN_LAST, WIN_FIRST - 16'd1,
                          WIN_LAST + 16'd1, 16'h0427, 16'h0428, 16'h0500, 16'h0600,
                          16'h0700, 16'h0401, 16'h0402, 16'h0403, 16'h0404, 16'h0405};

        // Random traffic; reads of RAM only ever target addresses already written.
        count = 0;
        while (count < RANDOM_WORDS)
        begin
            if (count == RANDOM_WORDS / 2)
            begin
                // Drain, then walk the line counter past its wrap and past the low byte.
                for (int i = 0; i < RASTER_RUN; i++)
                    pending_words.push_back('{OP_READ, ADDR_RASTER, 8'($urandom),
                                              i == 0});
                count += RASTER_RUN;
                continue;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                a = WIN_FIRST + 16'($urandom_range(0, 999));
                pending_words.push_back('{OP_WRITE, a, 8'($urandom), 1'b0});
                written_addrs.push_back(a);
            end
            else if (pick < 50)
            begin
                a = ($urandom_range(0, 9) == 0) ? odd_addrs[$urandom_range(0, 5)]
                                                : 16'($urandom_range(0, 65535));
                pending_words.push_back('{OP_WRITE, a, 8'($urandom), 1'b0});
                written_addrs.push_back(a);
            end
            else if (pick < 78)
            begin
                a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                pending_words.push_back('{OP_READ, a, 8'($urandom),
                                          $urandom_range(0, 99) == 0});
            end
            else if (pick < 92)
                pending_words.push_back('{OP_READ, ADDR_RASTER, 8'($urandom), 1'b0});
            else
                pending_words.push_back('{OP_READ, ADDR_KEYPORT, 8'($urandom), 1'b0});
            count++;
        end

        // Hold reset, then let the driver run the queue dry.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // Wait on to catch stray result words.
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
